@@ hw/rtl/ogdi_pkg.sv @@
// ----------------------------------------------------------------------------
// ogdi_pkg
// Shared types and constants of the occupancy grid disk inflation block.
// ----------------------------------------------------------------------------
package ogdi_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RADIUS = 15;

   localparam int COL_W  = 8;
   localparam int ROW_W  = 8;
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int DIM_W  = 9;
   localparam int VAL_W  = 8;
   localparam int THR_W  = 7;
   localparam int RAD_W  = 4;
   localparam int OFS_W  = RAD_W + 1;
   localparam int SQ_W   = 9;
   localparam int IDX_W  = 3;

   localparam logic signed [VAL_W-1:0] BLOCKED_VALUE = 8'sd100;
   localparam logic signed [VAL_W-1:0] UNKNOWN_VALUE = -8'sd1;

   typedef enum logic [IDX_W-1:0] {
      REG_GRID_WIDTH  = 3'd0,
      REG_GRID_HEIGHT = 3'd1,
      REG_OCC_THR     = 3'd2,
      REG_WIN_HALF    = 3'd3,
      REG_REACH_SQ    = 3'd4
   } reg_index_type;

   localparam logic [DIM_W-1:0] RST_GRID_WIDTH  = 9'd256;
   localparam logic [DIM_W-1:0] RST_GRID_HEIGHT = 9'd256;
   localparam logic [THR_W-1:0] RST_OCC_THR     = 7'd50;
   localparam logic [RAD_W-1:0] RST_WIN_HALF    = 4'd1;
   localparam logic [SQ_W-1:0]  RST_REACH_SQ    = 9'd1;

   typedef struct packed {
      logic [DIM_W-1:0] grid_width;
      logic [DIM_W-1:0] grid_height;
      logic [THR_W-1:0] occ_level;
      logic [RAD_W-1:0] window_half_size;
      logic [SQ_W-1:0]  reach_sq_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_SKIP    = 2'd1,
      OP_QUERY   = 2'd2,
      OP_OUTSIDE = 2'd3
   } op_type;

   typedef struct packed {
      op_type                  kind;
      logic [COL_W-1:0]        col_x;
      logic [ROW_W-1:0]        row_y;
      logic signed [VAL_W-1:0] cell_value;
   } entry_type;

   // grid size in use, saturated to the stored extent
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] lim);
      eff_dim = (v > lim) ? lim : v;
   endfunction

endpackage

@@ hw/rtl/ogdi_front.sv @@
// ----------------------------------------------------------------------------
// ogdi_front
// Takes request words and classifies them by mode and grid bounds.
// ----------------------------------------------------------------------------
module ogdi_front (
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_mode,
   input  logic [ogdi_pkg::COL_W-1:0]      req_col_x,
   input  logic [ogdi_pkg::ROW_W-1:0]      req_row_y,
   input  logic signed [ogdi_pkg::VAL_W-1:0] req_cell_value,
   input  ogdi_pkg::cfg_type               cfg,
   input  logic                            q_full,
   output logic                            q_push,
   output ogdi_pkg::entry_type             q_entry
);

   logic [ogdi_pkg::DIM_W-1:0] w_eff;
   logic [ogdi_pkg::DIM_W-1:0] h_eff;
   logic                       in_grid;

   assign w_eff  = ogdi_pkg::eff_dim(cfg.grid_width, ogdi_pkg::DIM_W'(ogdi_pkg::MAX_WIDTH));
   assign h_eff  = ogdi_pkg::eff_dim(cfg.grid_height, ogdi_pkg::DIM_W'(ogdi_pkg::MAX_HEIGHT));
   assign in_grid = ({1'b0, req_col_x} < w_eff) && ({1'b0, req_row_y} < h_eff);

   assign busy   = q_full;
   assign q_push = start && !q_full;

   always_comb begin
      q_entry.col_x      = req_col_x;
      q_entry.row_y      = req_row_y;
      q_entry.cell_value = req_cell_value;
      if (req_mode) begin
         q_entry.kind = in_grid ? ogdi_pkg::OP_QUERY : ogdi_pkg::OP_OUTSIDE;
      end else begin
         q_entry.kind = in_grid ? ogdi_pkg::OP_WRITE : ogdi_pkg::OP_SKIP;
      end
   end

endmodule

@@ hw/rtl/ogdi_queue.sv @@
// ----------------------------------------------------------------------------
// ogdi_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module ogdi_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ogdi_pkg::entry_type push_entry,
   input  logic                pop,
   output ogdi_pkg::entry_type pop_entry,
   output logic                not_empty,
   output logic                full
);

   ogdi_pkg::entry_type slot_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/ogdi_back.sv @@
// ----------------------------------------------------------------------------
// ogdi_back
// Holds the grid memory, carries out writes and walks the query window.
// ----------------------------------------------------------------------------
module ogdi_back (
   input  logic                            clock,
   input  logic                            reset,
   input  ogdi_pkg::cfg_type               cfg,
   input  logic                            q_valid,
   input  ogdi_pkg::entry_type             q_entry,
   output logic                            q_pop,
   output logic                            rsp_valid,
   output logic signed [ogdi_pkg::VAL_W-1:0] rsp_cell_out,
   output logic                            rsp_is_blocked
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   localparam int CW = ogdi_pkg::DIM_W + 1;

   logic [ogdi_pkg::VAL_W-1:0] grid_mem [ogdi_pkg::MAX_WIDTH * ogdi_pkg::MAX_HEIGHT];

   state_type                     state_ff, state_in;
   logic signed [ogdi_pkg::OFS_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [ogdi_pkg::COL_W-1:0]    qx_ff, qx_in;
   logic [ogdi_pkg::ROW_W-1:0]    qy_ff, qy_in;
   logic                          cen_ff, cen_in;
   logic                          chk_ff, chk_in;
   logic                          hit_ff, hit_in;
   logic [ogdi_pkg::VAL_W-1:0]    centre_ff, centre_in;
   logic [ogdi_pkg::VAL_W-1:0]    rd_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ogdi_pkg::VAL_W-1:0]    rsp_cell_ff, rsp_cell_in;
   logic                          rsp_blk_ff, rsp_blk_in;

   logic [ogdi_pkg::DIM_W-1:0]    w_eff, h_eff;
   logic signed [ogdi_pkg::OFS_W-1:0] r_pos, r_neg;
   logic signed [CW-1:0]          cx, cy;
   logic [ogdi_pkg::RAD_W-1:0]    adx, ady;
   logic [7:0]                    sqx, sqy;
   logic [ogdi_pkg::SQ_W-1:0]     d2;
   logic                          qual, occ, last;
   logic                          mem_we, rd_en;
   logic [ogdi_pkg::ADDR_W-1:0]   wr_addr, rd_addr;

   assign w_eff = ogdi_pkg::eff_dim(cfg.grid_width, ogdi_pkg::DIM_W'(ogdi_pkg::MAX_WIDTH));
   assign h_eff = ogdi_pkg::eff_dim(cfg.grid_height, ogdi_pkg::DIM_W'(ogdi_pkg::MAX_HEIGHT));
   assign r_pos = $signed({1'b0, cfg.window_half_size});
   assign r_neg = -r_pos;

   // neighbour under test
   assign cx   = $signed({2'b00, qx_ff}) + CW'(dx_ff);
   assign cy   = $signed({2'b00, qy_ff}) + CW'(dy_ff);
   assign adx  = dx_ff[ogdi_pkg::OFS_W-1] ? ogdi_pkg::RAD_W'(-dx_ff) : dx_ff[ogdi_pkg::RAD_W-1:0];
   assign ady  = dy_ff[ogdi_pkg::OFS_W-1] ? ogdi_pkg::RAD_W'(-dy_ff) : dy_ff[ogdi_pkg::RAD_W-1:0];
   assign sqx  = adx * adx;
   assign sqy  = ady * ady;
   assign d2   = {1'b0, sqx} + {1'b0, sqy};
   assign qual = !cx[CW-1] && (cx[ogdi_pkg::DIM_W-1:0] < w_eff)
              && !cy[CW-1] && (cy[ogdi_pkg::DIM_W-1:0] < h_eff)
              && (d2 <= cfg.reach_sq_limit);
   assign last = (dx_ff == r_pos) && (dy_ff == r_pos);
   assign occ  = $signed({rd_data_ff[ogdi_pkg::VAL_W-1], rd_data_ff})
              >= $signed({2'b00, cfg.occ_level});

   assign q_pop   = (state_ff == ST_IDLE) && q_valid;
   assign mem_we  = q_pop && (q_entry.kind == ogdi_pkg::OP_WRITE);
   assign wr_addr = {q_entry.row_y, q_entry.col_x};
   assign rd_en   = (q_pop && (q_entry.kind == ogdi_pkg::OP_QUERY)) || (state_ff == ST_SCAN);
   assign rd_addr = (state_ff == ST_SCAN) ? {cy[ogdi_pkg::ROW_W-1:0], cx[ogdi_pkg::COL_W-1:0]}
                                         : {q_entry.row_y, q_entry.col_x};

   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      cen_in       = 1'b0;
      chk_in       = 1'b0;
      hit_in       = hit_ff;
      centre_in    = centre_ff;
      rsp_valid_in = 1'b0;
      rsp_cell_in  = rsp_cell_ff;
      rsp_blk_in   = rsp_blk_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_entry.kind)
                  ogdi_pkg::OP_WRITE, ogdi_pkg::OP_SKIP: begin
                     rsp_valid_in = 1'b1;
                     rsp_cell_in  = q_entry.cell_value;
                     rsp_blk_in   = 1'b0;
                  end
                  ogdi_pkg::OP_OUTSIDE: begin
                     rsp_valid_in = 1'b1;
                     rsp_cell_in  = ogdi_pkg::UNKNOWN_VALUE;
                     rsp_blk_in   = 1'b0;
                  end
                  ogdi_pkg::OP_QUERY: begin
                     qx_in    = q_entry.col_x;
                     qy_in    = q_entry.row_y;
                     dx_in    = r_neg;
                     dy_in    = r_neg;
                     hit_in   = 1'b0;
                     cen_in   = 1'b1;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cen_ff) begin
               centre_in = rd_data_ff;
            end
            if (chk_ff && occ) begin
               hit_in = 1'b1;
            end
            chk_in = qual && !hit_ff;
            if (dx_ff == r_pos) begin
               dx_in = r_neg;
               dy_in = dy_ff + ogdi_pkg::OFS_W'(1);
            end else begin
               dx_in = dx_ff + ogdi_pkg::OFS_W'(1);
            end
            if (last || hit_ff) begin
               chk_in   = qual && !hit_ff;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            if (hit_ff || (chk_ff && occ)) begin
               rsp_cell_in = ogdi_pkg::BLOCKED_VALUE;
               rsp_blk_in  = 1'b1;
            end else begin
               rsp_cell_in = centre_ff;
               rsp_blk_in  = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cen_ff       <= 1'b0;
         chk_ff       <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cen_ff       <= cen_in;
         chk_ff       <= chk_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      centre_ff   <= centre_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_blk_ff  <= rsp_blk_in;
   end

   // grid memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[wr_addr] <= q_entry.cell_value;
      end
      if (rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_out   = $signed(rsp_cell_ff);
   assign rsp_is_blocked = rsp_blk_ff;

endmodule

@@ hw/rtl/occupancy_grid_disk_inflation.sv @@
// ----------------------------------------------------------------------------
// occupancy_grid_disk_inflation
// Occupancy grid with on-demand disk inflation of occupied cells.
//
// A request word is taken when start is high and busy is low. Mode 0 stores
// cell_value at (col_x, row_y) and echoes it; mode 1 returns 100 with
// rsp_is_blocked set when an occupied cell lies within the disk around the
// addressed cell, else the stored value; out-of-grid queries return -1.
// Each request gives exactly one response word, shown for one cycle with
// rsp_valid; the receiver cannot hold it off.
// Writes and out-of-grid queries pass through the queue register and the
// registered response stage when the back end is idle.
// A query occupies the back end while it walks the (2r+1)^2 cell window,
// r being window_half_size, and stops early once a hit is seen; the
// walk is set by the single read port of the grid memory, one cell a cycle.
// A two-word queue lets new words be taken while a query runs; busy is
// high while it is full.
// CSR writes (csr_we, csr_index, csr_wdata) land at once; change them only
// while the block is idle. Reset restores register defaults and empties
// the queue; grid contents are undefined until written.
// ----------------------------------------------------------------------------
module occupancy_grid_disk_inflation (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [ogdi_pkg::COL_W-1:0]        req_col_x,
   input  logic [ogdi_pkg::ROW_W-1:0]        req_row_y,
   input  logic signed [ogdi_pkg::VAL_W-1:0] req_cell_value,
   output logic                              rsp_valid,
   output logic signed [ogdi_pkg::VAL_W-1:0] rsp_cell_out,
   output logic                              rsp_is_blocked,
   input  logic                              csr_we,
   input  logic [ogdi_pkg::IDX_W-1:0]        csr_index,
   input  logic [ogdi_pkg::DIM_W-1:0]        csr_wdata
);

   ogdi_pkg::cfg_type   cfg_ff, cfg_in;
   ogdi_pkg::entry_type push_entry, pop_entry;
   logic                q_push, q_pop, q_not_empty, q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ogdi_pkg::REG_GRID_WIDTH:  cfg_in.grid_width  = csr_wdata;
            ogdi_pkg::REG_GRID_HEIGHT: cfg_in.grid_height = csr_wdata;
            ogdi_pkg::REG_OCC_THR:
               cfg_in.occ_level = csr_wdata[ogdi_pkg::THR_W-1:0];
            ogdi_pkg::REG_WIN_HALF:
               cfg_in.window_half_size = csr_wdata[ogdi_pkg::RAD_W-1:0];
            ogdi_pkg::REG_REACH_SQ:    cfg_in.reach_sq_limit = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width       <= ogdi_pkg::RST_GRID_WIDTH;
         cfg_ff.grid_height      <= ogdi_pkg::RST_GRID_HEIGHT;
         cfg_ff.occ_level        <= ogdi_pkg::RST_OCC_THR;
         cfg_ff.window_half_size <= ogdi_pkg::RST_WIN_HALF;
         cfg_ff.reach_sq_limit   <= ogdi_pkg::RST_REACH_SQ;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ogdi_front u_front (
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_col_x      (req_col_x),
      .req_row_y      (req_row_y),
      .req_cell_value (req_cell_value),
      .cfg            (cfg_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   ogdi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   ogdi_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_not_empty),
      .q_entry        (pop_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_cell_out   (rsp_cell_out),
      .rsp_is_blocked (rsp_is_blocked)
   );

endmodule

@@ test/tb_occupancy_grid_disk_inflation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_disk_inflation
// Self-checking bench for the occupancy grid disk inflation block.
//
// A mirror of the grid and of the registers works out the answer owed for
// each accepted request word. Every response word is checked against the
// oldest answer still owed. Directed words cover the reset settings, value
// and register extremes, and out-of-grid and zero-size grids. Random phases
// then load a patch of the grid and mix writes, queries and out-of-grid
// words under random settings and random gaps. Cells are only queried once
// their whole window inside the grid has been written.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_disk_inflation;

   localparam bit MODE_WRITE = 1'b0;
   localparam bit MODE_QUERY = 1'b1;
   localparam logic [ogdi_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int GRID_CELLS   = ogdi_pkg::MAX_WIDTH * ogdi_pkg::MAX_HEIGHT;
   localparam int PATCH_MAX    = 7;
   localparam int N_PHASES     = 8;
   localparam int PHASE_WORDS  = 75;
   localparam int DRAIN_CYCLES = 1000;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic signed [ogdi_pkg::VAL_W-1:0] cell_out;
      logic                              is_blocked;
   } answer_type;

   logic                              clock          = 1'b0;
   logic                              reset          = 1'b1;
   logic                              start          = 1'b0;
   logic                              busy;
   logic                              req_mode       = 1'b0;
   logic [ogdi_pkg::COL_W-1:0]        req_col_x      = '0;
   logic [ogdi_pkg::ROW_W-1:0]        req_row_y      = '0;
   logic signed [ogdi_pkg::VAL_W-1:0] req_cell_value = '0;
   logic                              rsp_valid;
   logic signed [ogdi_pkg::VAL_W-1:0] rsp_cell_out;
   logic                              rsp_is_blocked;
   logic                              csr_we         = 1'b0;
   logic [ogdi_pkg::IDX_W-1:0]        csr_index      = '0;
   logic [ogdi_pkg::DIM_W-1:0]        csr_wdata      = '0;

   logic signed [ogdi_pkg::VAL_W-1:0] grid_mirror [GRID_CELLS];
   bit                                cell_loaded [GRID_CELLS];
   ogdi_pkg::cfg_type                 settings;
   answer_type                        pending_answers [$];
   int                                mismatches = 0;
   int                                burst_left = 0;
   int                                high_pct   = 20;
   longint                            cycles     = 0;

   occupancy_grid_disk_inflation i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_col_x      (req_col_x),
      .req_row_y      (req_row_y),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_cell_out   (rsp_cell_out),
      .rsp_is_blocked (rsp_is_blocked),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("occupancy_grid_disk_inflation: mismatch");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] error: %s", $time, what);
      mismatches++;
   endtask

   function automatic int grid_cols();
      return (settings.grid_width > ogdi_pkg::MAX_WIDTH) ? ogdi_pkg::MAX_WIDTH
                                                         : int'(settings.grid_width);
   endfunction

   function automatic int grid_rows();
      return (settings.grid_height > ogdi_pkg::MAX_HEIGHT) ? ogdi_pkg::MAX_HEIGHT
                                                           : int'(settings.grid_height);
   endfunction

   function automatic int reach_radius();
      return (settings.window_half_size > ogdi_pkg::MAX_RADIUS)
             ? ogdi_pkg::MAX_RADIUS : int'(settings.window_half_size);
   endfunction

   // every in-grid cell of the square window has been written
   function automatic bit window_ready(input int x, input int y);
      int r, cx, cy;
      r = reach_radius();
      for (int dy = -r; dy <= r; dy++) begin
         for (int dx = -r; dx <= r; dx++) begin
            cx = x + dx;
            cy = y + dy;
            if (cx >= 0 && cx < grid_cols() && cy >= 0 && cy < grid_rows() &&
                !cell_loaded[cy * ogdi_pkg::MAX_WIDTH + cx])
               return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // answer owed for one word; a write also updates the mirror
   function automatic answer_type grid_answer(input bit mode, input int x, input int y,
                                              input logic signed [ogdi_pkg::VAL_W-1:0] v);
      answer_type a;
      int r, cx, cy;
      bit in_grid, hit;
      in_grid = (x < grid_cols()) && (y < grid_rows());
      a.is_blocked = 1'b0;
      if (mode == MODE_WRITE) begin
         if (in_grid) begin
            grid_mirror[y * ogdi_pkg::MAX_WIDTH + x] = v;
            cell_loaded[y * ogdi_pkg::MAX_WIDTH + x] = 1'b1;
         end
         a.cell_out = v;
         return a;
      end
      if (!in_grid) begin
         a.cell_out = ogdi_pkg::UNKNOWN_VALUE;
         return a;
      end
      r = reach_radius();
      hit = 1'b0;
      for (int dy = -r; dy <= r; dy++) begin
         for (int dx = -r; dx <= r; dx++) begin
            cx = x + dx;
            cy = y + dy;
            if (cx >= 0 && cx < grid_cols() && cy >= 0 && cy < grid_rows() &&
                dx * dx + dy * dy <= int'(settings.reach_sq_limit) &&
                int'(grid_mirror[cy * ogdi_pkg::MAX_WIDTH + cx]) >=
                int'(settings.occ_level))
               hit = 1'b1;
         end
      end
      a.is_blocked = hit;
      a.cell_out   = hit ? ogdi_pkg::BLOCKED_VALUE : grid_mirror[y * ogdi_pkg::MAX_WIDTH + x];
      return a;
   endfunction

   // mostly short gaps, a few long, and bursts with none
   function automatic int pick_gap();
      int sel;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (sel < 45) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // occupied with probability high_pct, free otherwise
   function automatic logic signed [ogdi_pkg::VAL_W-1:0] pick_value();
      int thr, v;
      thr = settings.occ_level;
      if ($urandom_range(0, 99) < high_pct) begin
         case ($urandom_range(0, 5))
            0:       v = $urandom_range(thr, 127);
            1:       v = (thr > 100) ? 127 : 100;
            default: v = (thr > 100) ? $urandom_range(thr, 127) : $urandom_range(thr, 100);
         endcase
      end else begin
         case ($urandom_range(0, 9))
            0:       v = -1 - int'($urandom_range(0, 127));
            1, 2:    v = -1;
            default: v = (thr == 0) ? -1 : $urandom_range(0, (thr > 101) ? 100 : thr - 1);
         endcase
      end
      return v[ogdi_pkg::VAL_W-1:0];
   endfunction

   task automatic send_word(input bit mode, input int x, input int y,
                            input logic signed [ogdi_pkg::VAL_W-1:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_mode       <= mode;
      req_col_x      <= x[ogdi_pkg::COL_W-1:0];
      req_row_y      <= y[ogdi_pkg::ROW_W-1:0];
      req_cell_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
      pending_answers = {pending_answers, grid_answer(mode, x, y, v)};
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input ogdi_pkg::cfg_type c, input bit poke_unused);
      csr_we    <= 1'b1;
      csr_index <= ogdi_pkg::REG_GRID_WIDTH;
      csr_wdata <= c.grid_width;
      @(posedge clock);
      csr_index <= ogdi_pkg::REG_GRID_HEIGHT;
      csr_wdata <= c.grid_height;
      @(posedge clock);
      csr_index <= ogdi_pkg::REG_OCC_THR;
      csr_wdata <= ogdi_pkg::DIM_W'(c.occ_level);
      @(posedge clock);
      csr_index <= ogdi_pkg::REG_WIN_HALF;
      csr_wdata <= ogdi_pkg::DIM_W'(c.window_half_size);
      @(posedge clock);
      csr_index <= ogdi_pkg::REG_REACH_SQ;
      csr_wdata <= c.reach_sq_limit;
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= REG_UNUSED;
         csr_wdata <= ogdi_pkg::DIM_W'($urandom);
         @(posedge clock);
      end
      csr_we   <= 1'b0;
      settings  = c;
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("response word %0d/%0b with none owed",
                                      rsp_cell_out, rsp_is_blocked));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_cell_out !== want.cell_out)
               report_mismatch($sformatf("cell_out %0d, expected %0d",
                                         rsp_cell_out, want.cell_out));
            if (rsp_is_blocked !== want.is_blocked)
               report_mismatch($sformatf("is_blocked %0b, expected %0b",
                                         rsp_is_blocked, want.is_blocked));
         end
      end
   end

   // reset settings: full grid, threshold 50, half size 1, reach 1
   task automatic test_reset_defaults();
      send_word(MODE_WRITE, 254, 254, 8'sd100);
      send_word(MODE_WRITE, 255, 254, 8'sd50);
      send_word(MODE_WRITE, 254, 255, 8'sd49);
      send_word(MODE_WRITE, 255, 255, -8'sd1);
      send_word(MODE_QUERY, 255, 255, ogdi_pkg::VAL_W'($urandom));
      send_word(MODE_WRITE, 255, 254, 8'sd10);
      // diagonal neighbour lies outside reach 1
      send_word(MODE_QUERY, 255, 255, ogdi_pkg::VAL_W'($urandom));
   endtask

   task automatic test_value_extremes();
      ogdi_pkg::cfg_type c;
      wait_idle();
      c = '{grid_width: 9'd3, grid_height: 9'd2, occ_level: 7'd127,
            window_half_size: 4'd15, reach_sq_limit: 9'd511};
      apply_settings(c, 1'b1);
      send_word(MODE_WRITE, 0, 0, -8'sd128);
      send_word(MODE_WRITE, 1, 0, 8'sd126);
      send_word(MODE_WRITE, 2, 0, -8'sd1);
      send_word(MODE_WRITE, 0, 1, 8'sd0);
      send_word(MODE_WRITE, 1, 1, 8'sd100);
      send_word(MODE_WRITE, 2, 1, 8'sd127);
      send_word(MODE_QUERY, 0, 0, ogdi_pkg::VAL_W'($urandom));
      // out of the grid in use: echo only, and unknown on query
      send_word(MODE_WRITE, 255, 255, -8'sd128);
      send_word(MODE_QUERY, 3, 0, ogdi_pkg::VAL_W'($urandom));
      send_word(MODE_QUERY, 0, 2, ogdi_pkg::VAL_W'($urandom));
      wait_idle();
      c.occ_level        = 7'd0;
      c.window_half_size = 4'd0;
      c.reach_sq_limit   = 9'd0;
      apply_settings(c, 1'b0);
      send_word(MODE_QUERY, 2, 0, ogdi_pkg::VAL_W'($urandom));
      send_word(MODE_QUERY, 0, 0, ogdi_pkg::VAL_W'($urandom));
      send_word(MODE_QUERY, 1, 1, ogdi_pkg::VAL_W'($urandom));
   endtask

   task automatic test_zero_size_grid();
      ogdi_pkg::cfg_type c;
      wait_idle();
      c = '{grid_width: 9'd0, grid_height: 9'd511, occ_level: 7'd50,
            window_half_size: 4'd1, reach_sq_limit: 9'd2};
      apply_settings(c, 1'b0);
      send_word(MODE_QUERY, 0, 0, ogdi_pkg::VAL_W'($urandom));
      send_word(MODE_WRITE, 255, 255, -8'sd128);
   endtask

   function automatic int random_dim();
      case ($urandom_range(0, 7))
         0:       return ogdi_pkg::MAX_WIDTH;
         1:       return $urandom_range(257, 511);
         2:       return $urandom_range(100, 255);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   function automatic ogdi_pkg::cfg_type random_settings();
      ogdi_pkg::cfg_type c;
      int r;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r = $urandom_range(0, 1);
         4, 5, 6:    r = $urandom_range(2, 4);
         default:    r = $urandom_range(5, ogdi_pkg::MAX_RADIUS);
      endcase
      c.window_half_size = ogdi_pkg::RAD_W'(r);
      // wide windows on small grids keep the load cost down
      if (r >= 5) begin
         c.grid_width  = ogdi_pkg::DIM_W'($urandom_range(1, PATCH_MAX));
         c.grid_height = ogdi_pkg::DIM_W'($urandom_range(1, PATCH_MAX));
      end else begin
         c.grid_width  = ogdi_pkg::DIM_W'(random_dim());
         c.grid_height = ogdi_pkg::DIM_W'(random_dim());
      end
      case ($urandom_range(0, 5))
         0:       c.occ_level = 7'd0;
         1:       c.occ_level = ogdi_pkg::THR_W'($urandom_range(101, 127));
         default: c.occ_level = ogdi_pkg::THR_W'($urandom_range(1, 100));
      endcase
      case ($urandom_range(0, 5))
         0:       c.reach_sq_limit = 9'd0;
         1:       c.reach_sq_limit = ogdi_pkg::SQ_W'($urandom_range(451, 511));
         default: c.reach_sq_limit = ogdi_pkg::SQ_W'($urandom_range(0, 2 * r * r + 1));
      endcase
      return c;
   endfunction

   task automatic send_outside(input int cols, input int rows);
      int x, y;
      if (cols < ogdi_pkg::MAX_WIDTH &&
          ($urandom_range(0, 1) == 1 || rows >= ogdi_pkg::MAX_HEIGHT)) begin
         x = $urandom_range(cols, 255);
         y = $urandom_range(0, 255);
      end else begin
         x = $urandom_range(0, 255);
         y = $urandom_range(rows, 255);
      end
      send_word(bit'($urandom_range(0, 1)), x, y, ogdi_pkg::VAL_W'($urandom));
   endtask

   task automatic test_random_phases();
      int cols, rows, pw, ph, x0, y0, x, y, sent, sel, tries;
      bit ready;
      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         apply_settings(random_settings(), bit'($urandom_range(0, 1)));
         case ($urandom_range(0, 4))
            0:       high_pct = 0;
            1:       high_pct = 5;
            2:       high_pct = 15;
            3:       high_pct = 40;
            default: high_pct = 80;
         endcase
         cols = grid_cols();
         rows = grid_rows();
         pw = (cols < PATCH_MAX) ? cols : PATCH_MAX;
         ph = (rows < PATCH_MAX) ? rows : PATCH_MAX;
         case ($urandom_range(0, 2))
            0: begin
               x0 = 0;
               y0 = 0;
            end
            1: begin
               x0 = cols - pw;
               y0 = rows - ph;
            end
            default: begin
               x0 = $urandom_range(0, cols - pw);
               y0 = $urandom_range(0, rows - ph);
            end
         endcase
         sent = 0;
         for (int yy = y0; yy < y0 + ph; yy++) begin
            for (int xx = x0; xx < x0 + pw; xx++) begin
               if (!cell_loaded[yy * ogdi_pkg::MAX_WIDTH + xx]) begin
                  send_word(MODE_WRITE, xx, yy, pick_value());
                  sent++;
               end
            end
         end
         while (sent < PHASE_WORDS) begin
            sel = $urandom_range(0, 99);
            if (pw == 0 || ph == 0 ||
                (sel < 12 && (cols < ogdi_pkg::MAX_WIDTH || rows < ogdi_pkg::MAX_HEIGHT))) begin
               send_outside(cols, rows);
            end else begin
               tries = 0;
               do begin
                  x = x0 + $urandom_range(0, pw - 1);
                  y = y0 + $urandom_range(0, ph - 1);
                  ready = window_ready(x, y);
                  tries++;
               end while (!ready && tries < 6);
               if (sel < 40 || !ready)
                  send_word(MODE_WRITE, x, y, pick_value());
               else
                  send_word(MODE_QUERY, x, y, ogdi_pkg::VAL_W'($urandom));
            end
            sent++;
         end
      end
   endtask

   initial begin
      settings = '{grid_width: ogdi_pkg::RST_GRID_WIDTH,
                   grid_height: ogdi_pkg::RST_GRID_HEIGHT,
                   occ_level: ogdi_pkg::RST_OCC_THR,
                   window_half_size: ogdi_pkg::RST_WIN_HALF,
                   reach_sq_limit: ogdi_pkg::RST_REACH_SQ};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_value_extremes();
      test_zero_size_grid();
      test_random_phases();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0)
         report_mismatch($sformatf("%0d response words never arrived",
                                   pending_answers.size()));
      if (mismatches == 0)
         $display("occupancy_grid_disk_inflation: match");
      else
         $display("occupancy_grid_disk_inflation: mismatch");
      $finish;
   end

endmodule
